@@ rtl/susu_pkg.sv @@
package susu_pkg;

	localparam int unsigned DefCapacity = 256;

	typedef enum logic [2:0] {
		OP_INSERT   = 3'd0,
		OP_REMOVE   = 3'd1,
		OP_CONTAINS = 3'd2,
		OP_READ     = 3'd3,
		OP_CLEAR    = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_DUP     = 3'd1,
		ST_FULL    = 3'd2,
		ST_MISSING = 3'd3,
		ST_BADIDX  = 3'd4
	} status_t;

	typedef struct packed {
		logic load;
		logic search_step;
		logic rd_issue;
		logic shift_up;
		logic shift_dn;
		logic write_val;
		logic cnt_inc;
		logic cnt_dec;
		logic cnt_clr;
		logic capture;
	} susu_cmd_t;

	typedef struct packed {
		logic search_done;
		logic hit;
		logic full;
		logic shift_done;
		logic idx_ok;
		logic rd_pend;
	} susu_sts_t;

endpackage

@@ rtl/susu_if.sv @@
interface susu_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [31:0] value;
	logic [7:0]  index;
	modport source (output valid, op, value, index, input ready);
	modport sink (input valid, op, value, index, output ready);
endinterface

interface susu_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [2:0]  status;
	logic [31:0] read_value;
	logic [8:0]  position;
	logic [8:0]  entry_count;
	modport source (output valid, found, status, read_value, position, entry_count,
		input ready);
	modport sink (input valid, found, status, read_value, position, entry_count,
		output ready);
endinterface

@@ rtl/susu_datapath.sv @@
module susu_datapath #(
	parameter int unsigned CAPACITY = susu_pkg::DefCapacity
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  susu_pkg::susu_cmd_t    cmd,
	output susu_pkg::susu_sts_t    sts,
	input  logic [2:0]             in_op,
	input  logic [31:0]            in_value,
	input  logic [7:0]             in_index,
	output logic                   r_found,
	output logic [2:0]             r_status,
	output logic [31:0]            r_read_value,
	output logic [8:0]             r_position,
	output logic [8:0]             r_entry_count
);
	import susu_pkg::*;

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = AW + 1;
	localparam int unsigned XW = (CW > 9) ? CW : 9;

	logic [31:0]   mem [CAPACITY];
	logic [31:0]   rd_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] lo_q, hi_q, mid_q, sp_q;
	logic          hit_q;
	logic [2:0]    op_q;
	logic [31:0]   val_q;
	logic [7:0]    idx_q;
	logic [CW-1:0] mid_c, pos_c, waddr_c, raddr_c;
	logic          we_c;
	logic [31:0]   wdata_c;
	logic          rd_pend_q;

	assign mid_c = lo_q + ((hi_q - lo_q) >> 1);
	assign pos_c = hit_q ? mid_q : lo_q;

	always_comb begin
		raddr_c = mid_c;
		if (cmd.shift_up)
			raddr_c = sp_q - CW'(2);
		else if (cmd.shift_dn)
			raddr_c = sp_q + CW'(1);
		else if (op_q == OP_READ)
			raddr_c = CW'(idx_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue)
			rd_q <= mem[raddr_c[AW-1:0]];
		if (we_c)
			mem[waddr_c[AW-1:0]] <= wdata_c;
	end

	// shift up: sp_q runs from count+1 down to pos+2, write mem[sp-1]=mem[sp-2] prefetched
	// shift down: sp_q runs from pos to count-2, write mem[sp]=mem[sp+1]
	always_comb begin
		we_c = 1'b0;
		waddr_c = sp_q;
		wdata_c = rd_q;
		if (cmd.write_val) begin
			we_c = 1'b1;
			waddr_c = pos_c;
			wdata_c = val_q;
		end else if ((cmd.shift_up || cmd.shift_dn) && rd_pend_q) begin
			we_c = 1'b1;
			waddr_c = cmd.shift_up ? sp_q - CW'(1) : sp_q;
		end
	end

	assign sts.search_done = !(lo_q < hi_q) || hit_q;
	assign sts.hit = hit_q;
	assign sts.full = count_q >= CW'(CAPACITY);
	assign sts.shift_done = cmd.shift_up ? (sp_q <= pos_c + CW'(1))
		: (sp_q + CW'(1) >= count_q);
	assign sts.idx_ok = XW'(idx_q) < XW'(count_q);
	assign sts.rd_pend = rd_pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			if (cmd.cnt_clr)
				count_q <= '0;
			else if (cmd.cnt_inc)
				count_q <= count_q + CW'(1);
			else if (cmd.cnt_dec)
				count_q <= count_q - CW'(1);
			rd_pend_q <= cmd.rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_op;
			val_q <= in_value;
			idx_q <= in_index;
			lo_q <= '0;
			hi_q <= count_q;
			hit_q <= 1'b0;
		end else if (cmd.search_step && rd_pend_q) begin
			if (rd_q == val_q)
				hit_q <= 1'b1;
			else if (rd_q < val_q)
				lo_q <= mid_q + CW'(1);
			else
				hi_q <= mid_q;
		end
		if (cmd.rd_issue && cmd.search_step)
			mid_q <= mid_c;
		if (cmd.load)
			sp_q <= '0;
		else if (!cmd.shift_up && !cmd.shift_dn)
			sp_q <= (op_q == OP_INSERT) ? count_q + CW'(1) : pos_c;
		else if (rd_pend_q)
			sp_q <= cmd.shift_up ? sp_q - CW'(1) : sp_q + CW'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			r_found <= 1'b0;
			r_status <= ST_OK;
			r_read_value <= '0;
			r_position <= 9'(pos_c);
			case (op_q)
				OP_INSERT: begin
					r_found <= hit_q;
					r_status <= hit_q ? ST_DUP : (sts.full ? ST_FULL : ST_OK);
				end
				OP_REMOVE, OP_CONTAINS: begin
					r_found <= hit_q;
					r_status <= hit_q ? ST_OK : ST_MISSING;
				end
				OP_READ: begin
					r_position <= {1'b0, idx_q};
					r_found <= sts.idx_ok;
					r_status <= sts.idx_ok ? ST_OK : ST_BADIDX;
					r_read_value <= sts.idx_ok ? rd_q : '0;
				end
				default: r_position <= '0;
			endcase
		end
	end

	assign r_entry_count = 9'(count_q);

endmodule

@@ rtl/susu_ctrl.sv @@
module susu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          in_op,
	output logic                out_valid,
	input  logic                out_ready,
	output susu_pkg::susu_cmd_t cmd,
	input  susu_pkg::susu_sts_t sts
);
	import susu_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SRCH  = 7'b0000010,
		S_SWAIT = 7'b0000100,
		S_DEC   = 7'b0001000,
		S_SHIFT = 7'b0010000,
		S_RD    = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic [2:0] op_q;
	logic       sh_up_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: if (in_valid) begin
				cmd.load = 1'b1;
				case (in_op)
					OP_INSERT, OP_REMOVE, OP_CONTAINS: state_d = S_SRCH;
					OP_READ: state_d = S_RD;
					default: state_d = S_DEC;
				endcase
			end
			S_SRCH: begin
				if (sts.search_done)
					state_d = S_DEC;
				else begin
					cmd.search_step = 1'b1;
					cmd.rd_issue = 1'b1;
					state_d = S_SWAIT;
				end
			end
			S_SWAIT: begin
				cmd.search_step = 1'b1;
				state_d = S_SRCH;
			end
			S_DEC: begin
				cmd.capture = 1'b1;
				state_d = S_OUT;
				if (op_q == OP_CLEAR)
					cmd.cnt_clr = 1'b1;
				else if (op_q == OP_INSERT && !sts.hit && !sts.full)
					state_d = S_SHIFT;
				else if (op_q == OP_REMOVE && sts.hit)
					state_d = S_SHIFT;
			end
			S_SHIFT: begin
				cmd.shift_up = sh_up_q;
				cmd.shift_dn = !sh_up_q;
				if (sts.shift_done) begin
					if (sh_up_q) begin
						cmd.write_val = 1'b1;
						cmd.cnt_inc = 1'b1;
					end else
						cmd.cnt_dec = 1'b1;
					state_d = S_OUT;
				end else if (!sts.rd_pend)
					cmd.rd_issue = 1'b1;
			end
			S_RD: begin
				cmd.rd_issue = 1'b1;
				state_d = S_DEC;
			end
			S_OUT: if (out_ready)
				state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_CONTAINS;
			sh_up_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				op_q <= in_op;
			sh_up_q <= (op_q == OP_INSERT);
		end
	end

endmodule

@@ rtl/sorted_unique_u32_set.sv @@
// Sorted set of up to CAPACITY distinct 32-bit values.
// Input channel "req" carries op, value and index; output channel "rsp"
// carries found, status, read_value, position and entry_count, one result
// per item.
// Ops: insert, remove, contains, read at index, clear.
// One item is in flight at a time; req is ready only while idle.
// Lookup is a binary search over a single-port memory, each probe a read
// followed by a compare, with p probes for p at most log2(count)+1.
// Insert then shifts the entries from the position up by one, remove shifts
// those above it down by one, one entry at a time as a read then a write.
// Read-at reads the entry at the index; clear resets the entry count.
// The result stays in a register until rsp.ready; no new item is taken
// while a result waits.
// Reset clears the entry count; the memory holds no valid data after reset
// and needs no clearing.
module sorted_unique_u32_set #(
	parameter int unsigned CAPACITY = susu_pkg::DefCapacity
) (
	input logic  clk,
	input logic  arst_n,
	susu_in_if.sink    req,
	susu_out_if.source rsp
);
	import susu_pkg::*;

	susu_cmd_t cmd;
	susu_sts_t sts;

	susu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_op     (req.op),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	susu_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_op         (req.op),
		.in_value      (req.value),
		.in_index      (req.index),
		.r_found       (rsp.found),
		.r_status      (rsp.status),
		.r_read_value  (rsp.read_value),
		.r_position    (rsp.position),
		.r_entry_count (rsp.entry_count)
	);

endmodule

@@ tb/sorted_unique_u32_set_tb.sv @@
`timescale 1ns / 100ps

module sorted_unique_u32_set_tb;
	import susu_pkg::*;

	localparam int unsigned SetCap = DefCapacity;

	typedef struct {
		logic        found;
		status_t     status;
		logic [31:0] read_value;
		logic [8:0]  position;
		logic [8:0]  entry_count;
	} set_result_t;

	typedef struct {
		logic [2:0]  op;
		logic [31:0] value;
		logic [7:0]  index;
		bit          typed;
		set_result_t want;
	} set_row_t;

	logic clk;
	logic arst_n;

	susu_in_if  req_if ();
	susu_out_if rsp_if ();

	sorted_unique_u32_set #(.CAPACITY(SetCap)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	logic [31:0] set_mem [SetCap];
	int unsigned set_cnt;
	set_result_t pending_q [$];
	int unsigned mismatches;
	logic [31:0] value_pool [24];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#(30_000_000);
		$display("sorted_unique_u32_set_tb: FAIL");
		$finish;
	end

	function automatic bit set_lookup(input logic [31:0] v, output int unsigned pos);
		pos = set_cnt;
		for (int unsigned i = 0; i < set_cnt; i++) begin
			if (set_mem[i] >= v) begin
				pos = i;
				return set_mem[i] == v;
			end
		end
		return 1'b0;
	endfunction

	function automatic set_result_t set_apply(input logic [2:0] op, input logic [31:0] v,
			input logic [7:0] idx);
		set_result_t r;
		int unsigned pos;
		bit hit;
		r = '{1'b0, ST_OK, 32'd0, 9'd0, 9'd0};
		pos = 0;
		case (op)
			OP_INSERT: begin
				hit = set_lookup(v, pos);
				if (hit) begin
					r.found = 1'b1;
					r.status = ST_DUP;
				end else if (set_cnt >= SetCap) begin
					r.status = ST_FULL;
				end else begin
					for (int unsigned i = set_cnt; i > pos; i--)
						set_mem[i] = set_mem[i - 1];
					set_mem[pos] = v;
					set_cnt++;
				end
			end
			OP_REMOVE: begin
				hit = set_lookup(v, pos);
				if (hit) begin
					r.found = 1'b1;
					for (int unsigned i = pos; i + 1 < set_cnt; i++)
						set_mem[i] = set_mem[i + 1];
					set_cnt--;
				end else begin
					r.status = ST_MISSING;
				end
			end
			OP_CONTAINS: begin
				hit = set_lookup(v, pos);
				if (hit)
					r.found = 1'b1;
				else
					r.status = ST_MISSING;
			end
			OP_READ: begin
				pos = idx;
				if (idx < set_cnt) begin
					r.found = 1'b1;
					r.read_value = set_mem[idx];
				end else begin
					r.status = ST_BADIDX;
				end
			end
			OP_CLEAR: set_cnt = 0;
			default: ;
		endcase
		r.position = pos[8:0];
		r.entry_count = set_cnt[8:0];
		return r;
	endfunction

	function automatic int unsigned draw_wait();
		if ($urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 13);
	endfunction

	task automatic send_item(input logic [2:0] op, input logic [31:0] v, input logic [7:0] idx,
			input bit typed, input set_result_t want);
		int unsigned gap;
		set_result_t r;
		gap = draw_wait();
		if (gap > 0) begin
			req_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.op = op;
		req_if.value = v;
		req_if.index = idx;
		req_if.valid = 1'b1;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		r = set_apply(op, v, idx);
		pending_q.push_back(typed ? want : r);
		@(negedge clk);
	endtask

	task automatic send_op(input logic [2:0] op, input logic [31:0] v, input logic [7:0] idx);
		set_result_t none;
		none = '{1'b0, ST_OK, 32'd0, 9'd0, 9'd0};
		send_item(op, v, idx, 1'b0, none);
	endtask

	task automatic report_mismatch(input string what, input set_result_t e, input set_result_t a);
		mismatches++;
		if (mismatches <= 10) begin
			$write("%0t: %s mismatch: expected f=%0d st=%0d rv=%h pos=%0d cnt=%0d, ",
				$realtime, what, e.found, e.status, e.read_value, e.position, e.entry_count);
			$display("got f=%0d st=%0d rv=%h pos=%0d cnt=%0d",
				a.found, a.status, a.read_value, a.position, a.entry_count);
		end
	endtask

	initial begin : result_check
		set_result_t got;
		set_result_t want;
		int unsigned stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				rsp_if.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_if.ready = 1'b1;
			@(posedge clk);
			while (!rsp_if.valid)
				@(posedge clk);
			got.found = rsp_if.found;
			got.status = status_t'(rsp_if.status);
			got.read_value = rsp_if.read_value;
			got.position = rsp_if.position;
			got.entry_count = rsp_if.entry_count;
			if (pending_q.size() == 0) begin
				want = '{1'b0, ST_OK, 32'd0, 9'd0, 9'd0};
				report_mismatch("unexpected result", want, got);
			end else begin
				want = pending_q.pop_front();
				if (got.found !== want.found || got.status !== want.status ||
						got.read_value !== want.read_value ||
						got.position !== want.position ||
						got.entry_count !== want.entry_count)
					report_mismatch("result", want, got);
			end
			@(negedge clk);
		end
	end

	initial begin : stimulus
		set_row_t rows [$];
		logic [2:0] op;
		logic [31:0] v;
		logic [7:0] idx;
		int unsigned sel;
		int unsigned drain;

		clk = 1'b0;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.op = '0;
		req_if.value = '0;
		req_if.index = '0;
		rsp_if.ready = 1'b0;
		set_cnt = 0;
		mismatches = 0;
		foreach (value_pool[i])
			value_pool[i] = $urandom();
		value_pool[0] = 32'd0;
		value_pool[1] = 32'hFFFF_FFFF;

		rows.push_back('{OP_READ, 32'd0, 8'd0, 1, '{1'b0, ST_BADIDX, 32'd0, 9'd0, 9'd0}});
		rows.push_back('{OP_CONTAINS, 32'd0, 8'd0, 1, '{1'b0, ST_MISSING, 32'd0, 9'd0, 9'd0}});
		rows.push_back('{OP_REMOVE, 32'hFFFF_FFFF, 8'd0, 1,
			'{1'b0, ST_MISSING, 32'd0, 9'd0, 9'd0}});
		rows.push_back('{OP_INSERT, 32'd0, 8'd0, 1, '{1'b0, ST_OK, 32'd0, 9'd0, 9'd1}});
		rows.push_back('{OP_INSERT, 32'hFFFF_FFFF, 8'd0, 1,
			'{1'b0, ST_OK, 32'd0, 9'd1, 9'd2}});
		rows.push_back('{OP_READ, 32'd0, 8'd1, 1,
			'{1'b1, ST_OK, 32'hFFFF_FFFF, 9'd1, 9'd2}});
		rows.push_back('{OP_INSERT, 32'd0, 8'd0, 1, '{1'b1, ST_DUP, 32'd0, 9'd0, 9'd2}});
		rows.push_back('{OP_READ, 32'd0, 8'd255, 1, '{1'b0, ST_BADIDX, 32'd0, 9'd255, 9'd2}});
		rows.push_back('{3'd5, 32'hFFFF_FFFF, 8'hFF, 1, '{1'b0, ST_OK, 32'd0, 9'd0, 9'd2}});
		rows.push_back('{3'd6, 32'd0, 8'd0, 1, '{1'b0, ST_OK, 32'd0, 9'd0, 9'd2}});
		rows.push_back('{3'd7, 32'h5555_AAAA, 8'h55, 1, '{1'b0, ST_OK, 32'd0, 9'd0, 9'd2}});
		rows.push_back('{OP_INSERT, 32'h8000_0000, 8'd0, 0, '{1'b0, ST_OK, 32'd0, 9'd0, 9'd0}});
		rows.push_back('{OP_INSERT, 32'h0000_0001, 8'd0, 0, '{1'b0, ST_OK, 32'd0, 9'd0, 9'd0}});
		rows.push_back('{OP_CONTAINS, 32'h8000_0000, 8'd0, 0,
			'{1'b0, ST_OK, 32'd0, 9'd0, 9'd0}});
		rows.push_back('{OP_CONTAINS, 32'h7FFF_FFFF, 8'd0, 0,
			'{1'b0, ST_OK, 32'd0, 9'd0, 9'd0}});
		rows.push_back('{OP_READ, 32'd0, 8'd2, 0, '{1'b0, ST_OK, 32'd0, 9'd0, 9'd0}});
		rows.push_back('{OP_REMOVE, 32'd0, 8'd0, 0, '{1'b0, ST_OK, 32'd0, 9'd0, 9'd0}});
		rows.push_back('{OP_REMOVE, 32'h8000_0000, 8'd0, 0, '{1'b0, ST_OK, 32'd0, 9'd0, 9'd0}});
		rows.push_back('{OP_READ, 32'd0, 8'd0, 0, '{1'b0, ST_OK, 32'd0, 9'd0, 9'd0}});
		rows.push_back('{OP_CLEAR, 32'hFFFF_FFFF, 8'hFF, 1, '{1'b0, ST_OK, 32'd0, 9'd0, 9'd0}});
		rows.push_back('{OP_READ, 32'd0, 8'd0, 1, '{1'b0, ST_BADIDX, 32'd0, 9'd0, 9'd0}});

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i])
			send_item(rows[i].op, rows[i].value, rows[i].index, rows[i].typed, rows[i].want);

		// random operations over a small value pool so hits and misses both occur
		for (int n = 0; n < 160; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 35) op = OP_INSERT;
			else if (sel < 55) op = OP_REMOVE;
			else if (sel < 75) op = OP_CONTAINS;
			else if (sel < 90) op = OP_READ;
			else if (sel < 93) op = OP_CLEAR;
			else op = 3'($urandom_range(5, 7));
			if ($urandom_range(0, 4) != 0)
				v = value_pool[$urandom_range(0, 23)];
			else
				v = $urandom();
			if ($urandom_range(0, 1) == 0)
				idx = 8'($urandom_range(0, set_cnt));
			else
				idx = 8'($urandom());
			send_op(op, v, idx);
		end

		// fill to capacity with ascending values, then probe the full store
		send_op(OP_CLEAR, $urandom(), 8'($urandom()));
		for (int unsigned i = 0; i < SetCap; i++)
			send_op(OP_INSERT, (i << 24) | (i << 1) | 32'h10, 8'($urandom()));
		send_op(OP_INSERT, 32'd0, 8'd0);
		send_op(OP_INSERT, 32'hFFFF_FFFF, 8'd0);
		send_op(OP_INSERT, 32'h0000_0010, 8'd0);
		send_op(OP_READ, 32'd0, 8'd255);
		send_op(OP_READ, 32'd0, 8'd0);
		send_op(OP_CONTAINS, (32'd255 << 24) | (32'd255 << 1) | 32'h10, 8'd0);
		send_op(OP_REMOVE, (32'd255 << 24) | (32'd255 << 1) | 32'h10, 8'd0);
		send_op(OP_INSERT, 32'hFFFF_FFFF, 8'd0);
		send_op(OP_READ, 32'd0, 8'd255);
		send_op(OP_REMOVE, 32'h0000_0010, 8'd0);
		send_op(OP_INSERT, 32'd0, 8'd0);
		send_op(OP_READ, 32'd0, 8'd0);
		send_op(OP_CLEAR, 32'd0, 8'd0);
		send_op(OP_CONTAINS, 32'd0, 8'd0);

		req_if.valid = 1'b0;
		drain = 0;
		while (pending_q.size() != 0 && drain < 200_000) begin
			@(negedge clk);
			drain++;
		end
		repeat (600) @(negedge clk);

		if (mismatches == 0 && pending_q.size() == 0)
			$display("sorted_unique_u32_set_tb: PASS");
		else
			$display("sorted_unique_u32_set_tb: FAIL");
		$finish;
	end

endmodule
